[src/block_bitmap_allocator_unit_assert.svh]
// Assertion macros for the block bitmap allocator.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bba assertion failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bba assertion failed");

`endif

[src/bba_pkg.sv]
// Shared constants, types and helpers for the block bitmap allocator.
// No dependencies; used by bba_seq and block_bitmap_allocator_unit.
package bba_pkg;

	localparam int NUM_BLOCKS  = 256;
	localparam int BLOCK_BYTES = 512;
	localparam int MAX_RUN     = 16;
	localparam int RESULT_CAP  = 16;
	localparam int RUN_LIMIT   = (MAX_RUN < RESULT_CAP) ? MAX_RUN : RESULT_CAP;

	localparam int BYTE_W    = 14;
	localparam int BLK_W     = 8;
	localparam int CNT_W     = 9;
	localparam int STAT_W    = 2;
	localparam int ROW_W     = 16;
	localparam int ROW_BITS  = $clog2(ROW_W);
	localparam int ROWS      = NUM_BLOCKS / ROW_W;
	localparam int ROW_AW    = $clog2(ROWS);
	localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int SUM_W     = BYTE_W + 1;
	localparam int NEED_W    = SUM_W - BLK_SHIFT;
	localparam int REM_W     = $clog2(RUN_LIMIT + 1);

	localparam int IN_DW  = 24;
	localparam int OUT_DW = 24;

	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [ROW_AW-1:0]   rowa_t;
	typedef logic [ROW_BITS-1:0] pos_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [NEED_W-1:0]   need_t;
	typedef logic [REM_W-1:0]    rem_t;
	typedef logic [BLK_W-1:0]    blk_t;
	typedef logic [STAT_W-1:0]   stat_t;

	localparam stat_t STAT_OK           = 2'd0;
	localparam stat_t STAT_BAD_SIZE     = 2'd1;
	localparam stat_t STAT_NO_SPACE     = 2'd2;
	localparam stat_t STAT_ALREADY_FREE = 2'd3;

	typedef struct packed {
		stat_t status;
		blk_t  blk;
		logic  last;
		cnt_t  free_count;
	} res_t;

	// lowest clear bit of a row; caller guarantees one exists
	function automatic pos_t lowest_zero(input row_t bits);
		pos_t p;
		p = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (!bits[i]) begin
				p = pos_t'(i);
			end
		end
		return p;
	endfunction

endpackage

[src/block_bitmap_allocator_unit.sv]
// Block bitmap allocator top level: stream ports, output register, bitmap RAM.
// Depends on bba_pkg, bba_ram and bba_seq.
//
// Usage: the input stream carries one request per transaction. s_axis_tuser
// selects allocate (0) or free (1); s_axis_tdata holds the byte count and the
// block index. An allocate grants the lowest free blocks, all or none, and
// returns one transaction per granted block on the output stream, tlast on
// the final one. Every other request returns a single transaction with tlast.
// One request is in flight at a time; s_axis_tready is high only while idle.
// An error answers straight from the checks, without touching the bitmap; a
// free reads its row, then answers and writes it back. An allocate reads the
// bitmap one 16-block row per RAM access (with a write-back for each row it
// passes), then grants one block a cycle while the output register is free.
// The free-block count is checked before any row is read, so a request that
// cannot fit also answers without scanning the bitmap.
// Reset clears the bitmap through per-row valid bits and sets the count to
// 256; no clearing pass is needed. If the receiver stalls, the result waits
// in the output register and the sequencer holds until it is taken.
module block_bitmap_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bba_pkg::IN_DW-1:0]     s_axis_tdata,  // byte_count[13:0], block_index[21:14]
	input  logic                          s_axis_tuser,  // action
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bba_pkg::OUT_DW-1:0]    m_axis_tdata,  // status[1:0], granted_block[9:2], free_count[18:10]
	output logic                          m_axis_tlast
);

	logic            slot_free;
	logic            res_valid;
	bba_pkg::res_t   res;
	bba_pkg::res_t   out_q;
	logic            out_valid_q;
	logic            ram_we;
	logic            ram_re;
	bba_pkg::rowa_t  ram_waddr;
	bba_pkg::rowa_t  ram_raddr;
	bba_pkg::row_t   ram_wdata;
	bba_pkg::row_t   ram_rdata;

	assign slot_free = !out_valid_q || m_axis_tready;

	bba_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_bytes  (s_axis_tdata[bba_pkg::BYTE_W-1:0]),
		.in_idx    (s_axis_tdata[bba_pkg::BYTE_W +: bba_pkg::BLK_W]),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bba_ram #(
		.WIDTH (bba_pkg::ROW_W),
		.DEPTH (bba_pkg::ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = bba_pkg::OUT_DW'({out_q.free_count, out_q.blk, out_q.status});

endmodule

[src/bba_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the used bitmap rows.
module bba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/bba_seq.sv]
// Allocation sequencer: read-modify-write of bitmap rows, free count, result build.
// Depends on bba_pkg and block_bitmap_allocator_unit_assert.svh.
`include "block_bitmap_allocator_unit_assert.svh"

module bba_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_action,
	input  logic [bba_pkg::BYTE_W-1:0] in_bytes,
	input  bba_pkg::blk_t         in_idx,
	input  logic                  slot_free,
	output logic                  res_valid,
	output bba_pkg::res_t         res,
	output logic                  ram_we,
	output bba_pkg::rowa_t        ram_waddr,
	output bba_pkg::row_t         ram_wdata,
	output logic                  ram_re,
	output bba_pkg::rowa_t        ram_raddr,
	input  bba_pkg::row_t         ram_rdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_FREE  = 3'd3;
	localparam logic [2:0] ST_GRANT = 3'd4;
	localparam logic [2:0] ST_ERR   = 3'd5;

	logic [2:0]              state_q, state_d;
	bba_pkg::cnt_t           cnt_q, cnt_d;
	logic [bba_pkg::ROWS-1:0] vld_q, vld_d;
	bba_pkg::rem_t           rem_q, rem_d;
	bba_pkg::rowa_t          row_q, row_d;
	bba_pkg::row_t           bits_q, bits_d;
	bba_pkg::stat_t          err_q, err_d;
	logic                    act_q, act_d;
	bba_pkg::pos_t           bit_q, bit_d;

	bba_pkg::need_t          need;
	bba_pkg::pos_t           pos;
	bba_pkg::row_t           bits_set;

	assign need = bba_pkg::need_t'((bba_pkg::sum_t'(in_bytes)
		+ bba_pkg::sum_t'(bba_pkg::BLOCK_BYTES - 1)) >> bba_pkg::BLK_SHIFT);
	assign pos      = bba_pkg::lowest_zero(bits_q);
	assign bits_set = bits_q | (bba_pkg::row_t'(1) << pos);

	assign in_ready  = (state_q == ST_IDLE);
	assign ram_raddr = row_q;
	assign ram_waddr = row_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		vld_d     = vld_q;
		rem_d     = rem_q;
		row_d     = row_q;
		bits_d    = bits_q;
		err_d     = err_q;
		act_d     = act_q;
		bit_d     = bit_q;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = bits_q;
		res_valid = 1'b0;
		res       = '{status: bba_pkg::STAT_OK, blk: '0, last: 1'b1, free_count: cnt_q};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					act_d = in_action;
					bit_d = in_idx[bba_pkg::ROW_BITS-1:0];
					rem_d = bba_pkg::rem_t'(need);
					if (in_action) begin
						row_d = in_idx[bba_pkg::BLK_W-1:bba_pkg::ROW_BITS];
						if (bba_pkg::cnt_t'(in_idx) >= bba_pkg::cnt_t'(bba_pkg::NUM_BLOCKS)) begin
							err_d   = bba_pkg::STAT_ALREADY_FREE;
							state_d = ST_ERR;
						end else begin
							state_d = ST_RD;
						end
					end else begin
						row_d = '0;
						if (need == '0 || need > bba_pkg::need_t'(bba_pkg::RUN_LIMIT)) begin
							err_d   = bba_pkg::STAT_BAD_SIZE;
							state_d = ST_ERR;
						end else if (bba_pkg::cnt_t'(need) > cnt_q) begin
							err_d   = bba_pkg::STAT_NO_SPACE;
							state_d = ST_ERR;
						end else begin
							state_d = ST_RD;
						end
					end
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				bits_d  = vld_q[row_q] ? ram_rdata : '0;
				state_d = act_q ? ST_FREE : ST_GRANT;
			end
			ST_FREE: begin
				if (slot_free) begin
					res_valid = 1'b1;
					if (bits_q[bit_q]) begin
						ram_we           = 1'b1;
						ram_wdata        = bits_q & ~(bba_pkg::row_t'(1) << bit_q);
						vld_d[row_q]     = 1'b1;
						cnt_d            = cnt_q + 1'b1;
						res.free_count   = cnt_q + 1'b1;
					end else begin
						res.status = bba_pkg::STAT_ALREADY_FREE;
					end
					state_d = ST_IDLE;
				end
			end
			ST_GRANT: begin
				if (&bits_q) begin
					// row exhausted: write back and move on
					ram_we       = 1'b1;
					vld_d[row_q] = 1'b1;
					row_d        = row_q + 1'b1;
					state_d      = ST_RD;
				end else if (slot_free) begin
					res_valid      = 1'b1;
					res.blk        = {row_q, pos};
					res.last       = (rem_q == bba_pkg::rem_t'(1));
					res.free_count = cnt_q - 1'b1;
					bits_d         = bits_set;
					cnt_d          = cnt_q - 1'b1;
					rem_d          = rem_q - 1'b1;
					if (rem_q == bba_pkg::rem_t'(1)) begin
						ram_we       = 1'b1;
						ram_wdata    = bits_set;
						vld_d[row_q] = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (slot_free) begin
					res_valid  = 1'b1;
					res.status = err_q;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= bba_pkg::cnt_t'(bba_pkg::NUM_BLOCKS);
			vld_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			vld_q   <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		row_q  <= row_d;
		bits_q <= bits_d;
		err_q  <= err_d;
		act_q  <= act_d;
		bit_q  <= bit_d;
	end

	`BBA_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= bba_pkg::cnt_t'(bba_pkg::NUM_BLOCKS))
	`BBA_ASSERT_IMPL(a_res_slot, clk, arst_n, res_valid, slot_free)
	`BBA_ASSERT_IMPL(a_grant_rem, clk, arst_n, state_q == ST_GRANT, rem_q != '0)
	`BBA_ASSERT_NEXT(a_last_idle, clk, arst_n, res_valid && res.last, state_q == ST_IDLE)

endmodule

[sim/block_bitmap_allocator_unit_test.sv]
// Self-checking testbench for block_bitmap_allocator_unit: streams allocate and free requests,
// tracks the bitmap and free count alongside, and compares every output transaction.
// Depends on bba_pkg and the RTL under src.
`timescale 1ns / 1ps

module block_bitmap_allocator_unit_test;
	import bba_pkg::*;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam int RANDOM_REQS  = 86;
	localparam int HOLD_LEN     = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic              act;
		logic [BYTE_W-1:0] bytes;
		logic [BLK_W-1:0]  idx;
	} bba_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_DW-1:0]  s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_DW-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	bba_req_t req_q[$];
	res_t     answers_due[$];
	bba_req_t drv_req;
	res_t     want;

	logic [NUM_BLOCKS-1:0] blk_taken = '0;
	int                    blocks_free = NUM_BLOCKS;

	int       accepted = 0;
	int       err_cnt = 0;
	int       cycle_cnt = 0;
	int       hold_cycles = 0;
	bit       hold_done = 1'b0;
	int       send_idle;
	int       recv_idle;

	block_bitmap_allocator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	assign send_idle = (accepted < 46) ? 11 : (accepted < 92) ? 75 : 0;
	assign recv_idle = (accepted < 46) ? 75 : (accepted < 92) ? 11 : 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: ERROR %s", $time, msg);
		err_cnt++;
	endtask

	task automatic queue_req(input logic act, input int bytes, input int idx);
		bba_req_t rq;
		rq.act   = act;
		rq.bytes = BYTE_W'(bytes);
		rq.idx   = BLK_W'(idx);
		req_q.push_back(rq);
	endtask

	// first-fit bitmap update; pushes every answer the request produces
	task automatic apply_request(input bba_req_t rq);
		res_t a;
		int   need;
		int   k;
		a = '0;
		if (rq.act == ACT_FREE) begin
			a.last = 1'b1;
			if (!blk_taken[rq.idx]) begin
				a.status = STAT_ALREADY_FREE;
			end else begin
				blk_taken[rq.idx] = 1'b0;
				blocks_free++;
				a.status = STAT_OK;
			end
			a.free_count = cnt_t'(blocks_free);
			answers_due.push_back(a);
		end else begin
			need = (int'(rq.bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
			if (need == 0 || need > RUN_LIMIT) begin
				a.status     = STAT_BAD_SIZE;
				a.last       = 1'b1;
				a.free_count = cnt_t'(blocks_free);
				answers_due.push_back(a);
			end else if (need > blocks_free) begin
				a.status     = STAT_NO_SPACE;
				a.last       = 1'b1;
				a.free_count = cnt_t'(blocks_free);
				answers_due.push_back(a);
			end else begin
				k = 0;
				for (int i = 0; i < NUM_BLOCKS && k < need; i++) begin
					if (!blk_taken[i]) begin
						blk_taken[i] = 1'b1;
						blocks_free--;
						k++;
						a.status     = STAT_OK;
						a.blk        = blk_t'(i);
						a.last       = (k == need);
						a.free_count = cnt_t'(blocks_free);
						answers_due.push_back(a);
					end
				end
			end
		end
	endtask

	function automatic int pick_taken();
		int start;
		int j;
		start = $urandom_range(0, NUM_BLOCKS - 1);
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			j = (start + i) % NUM_BLOCKS;
			if (blk_taken[j]) begin
				return j;
			end
		end
		return -1;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_request(drv_req);
				accepted <= accepted + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					drv_req = req_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= IN_DW'({drv_req.idx, drv_req.bytes});
					s_axis_tuser  <= drv_req.act;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done   <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end else if (!hold_done && accepted >= 30) begin
			hold_cycles <= HOLD_LEN;
			hold_done   <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answers_due.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction data=%h last=%b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = answers_due.pop_front();
				if (m_axis_tdata[1:0] !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						m_axis_tdata[1:0], want.status));
				if (m_axis_tdata[9:2] !== want.blk)
					report_mismatch($sformatf("granted_block %0d, want %0d",
						m_axis_tdata[9:2], want.blk));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
				if (m_axis_tdata[18:10] !== want.free_count)
					report_mismatch($sformatf("free_count %0d, want %0d",
						m_axis_tdata[18:10], want.free_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("block_bitmap_allocator_unit: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		bba_req_t rq;
		int       r;
		int       slot;
		bit       draining;
		draining = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_req(ACT_FREE, 0, 0);
		queue_req(ACT_ALLOC, 0, 0);
		queue_req(ACT_ALLOC, 8193, 0);
		queue_req(ACT_ALLOC, 16383, 255);
		queue_req(ACT_ALLOC, 1, 0);
		queue_req(ACT_ALLOC, 513, 0);
		queue_req(ACT_FREE, 0, 1);
		queue_req(ACT_FREE, 0, 1);
		queue_req(ACT_ALLOC, 8192, 0);    // fills the hole at block 1 first
		repeat (14) queue_req(ACT_ALLOC, 8192, 0);
		queue_req(ACT_ALLOC, 8192, 0);    // 14 free: no space
		queue_req(ACT_ALLOC, 7168, 0);    // takes exactly the rest
		queue_req(ACT_ALLOC, 1, 0);
		queue_req(ACT_FREE, 16383, 255);
		queue_req(ACT_FREE, 0, 255);

		// fill toward full, then release scattered blocks, and again
		repeat (RANDOM_REQS) begin
			while (req_q.size() >= 2) @(posedge clk);
			if (blocks_free < 8) draining = 1'b1;
			else if (blocks_free >= 32) draining = 1'b0;
			rq.act   = ACT_ALLOC;
			rq.bytes = BYTE_W'($urandom_range(1, 8192));
			rq.idx   = BLK_W'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < 6) begin
				rq.bytes = ($urandom_range(0, 3) == 0) ? '0 : BYTE_W'($urandom_range(8193, 16383));
			end else if (r < 12) begin
				rq.act   = ACT_FREE;
				rq.bytes = BYTE_W'($urandom);
			end else if (draining) begin
				slot = pick_taken();
				if (slot >= 0) begin
					rq.act   = ACT_FREE;
					rq.idx   = BLK_W'(slot);
					rq.bytes = BYTE_W'($urandom);
				end
			end
			req_q.push_back(rq);
		end

		while (req_q.size() != 0 || s_axis_tvalid || answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("block_bitmap_allocator_unit: match");
		else
			$display("block_bitmap_allocator_unit: mismatch");
		$finish;
	end

endmodule
